/* sv/vfu_pkg.sv */
`timescale 1ns / 1ps

package vfu_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_BITS = 16;
  localparam int NYQ_BITS = 14;
  localparam int REM_BITS = NYQ_BITS + 2;
  localparam int IDX_BITS = 2;

  localparam logic [IDX_BITS-1:0] REG_CENTER  = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_NYQUIST = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_BAD     = 2'd2;

  localparam logic signed [CFG_BITS-1:0] CENTER_RESET = 16'sh0000;
  localparam logic [NYQ_BITS-1:0]        NYQ_RESET    = 14'd1;
  localparam logic signed [CFG_BITS-1:0] BAD_RESET    = 16'sh8000;

  localparam int FOLD_POS_LIMIT = 32767;
  localparam int FOLD_NEG_LIMIT = 32768;
  localparam logic signed [15:0] FOLD_MAX = 16'sh7fff;
  localparam logic signed [15:0] FOLD_MIN = 16'sh8000;

  typedef struct packed {
    logic active;
    logic neg;
    logic last;
  } vfu_ctl_t;

  function automatic int div_width(int sample_bits);
    return ((sample_bits > CFG_BITS) ? sample_bits : CFG_BITS) + 1;
  endfunction

endpackage

/* sv/velocity_forced_unfold.sv */
`timescale 1ns / 1ps
// forced unfolding of doppler velocity gates about a center velocity
// gate channel: gate_valid / gate_stall with sample, in_boundary, last_gate
// result channel: result_valid / result_stall with sample_out, fold_count,
//   saturated, last_out; one result transaction per gate transaction, in order
// config port: cfg_wr_en, cfg_index, cfg_data; 0 center, 1 nyquist, 2 bad value
//   write only while the pipeline is empty; other indexes are ignored
// throughput: one gate per cycle, sustained while result_stall stays low
// path: front register, fold divider stages, fold register, output register; the
//   fold divider resolves one quotient bit per pipeline stage
// reset clears all stage valid bits and loads center 0, nyquist 1,
//   bad value -32768
// a stall on the result side holds the output register; each stage keeps
//   taking data while the stage after it has room, so gates keep entering
//   until the pipeline is full, then gate_stall rises
module velocity_forced_unfold #(
  parameter int SAMPLE_BITS = vfu_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [vfu_pkg::IDX_BITS-1:0]        cfg_index,
  input  logic [vfu_pkg::CFG_BITS-1:0]        cfg_data,
  input  logic                                gate_valid,
  output logic                                gate_stall,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  input  logic                                in_boundary,
  input  logic                                last_gate,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [SAMPLE_BITS-1:0]       sample_out,
  output logic signed [15:0]                  fold_count,
  output logic                                saturated,
  output logic                                last_out
);
  import vfu_pkg::*;

  localparam int DW = div_width(SAMPLE_BITS);

  logic signed [CFG_BITS-1:0] center;
  logic [NYQ_BITS-1:0]        nyq;
  logic signed [CFG_BITS-1:0] bad;
  logic [NYQ_BITS:0]          two_n;

  logic                          front_ready;
  logic                          div_v [0:DW];
  logic                          div_ready [0:DW];
  logic signed [SAMPLE_BITS-1:0] div_s [0:DW];
  logic [DW-1:0]                 div_dvd [0:DW];
  logic [DW-1:0]                 div_q [0:DW];
  logic [REM_BITS-1:0]           div_rem [0:DW];
  vfu_ctl_t                      div_ctl [0:DW];

  logic                          fold_v;
  logic                          out_ready;
  logic signed [SAMPLE_BITS-1:0] fold_s;
  logic [DW-1:0]                 fold_prod;
  logic signed [15:0]            fold_n;
  vfu_ctl_t                      fold_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      center <= CENTER_RESET;
      nyq <= NYQ_RESET;
      bad <= BAD_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CENTER:  center <= cfg_data;
        REG_NYQUIST: nyq <= cfg_data[NYQ_BITS-1:0];
        REG_BAD:     bad <= cfg_data;
        default: ;
      endcase
    end
  end

  assign two_n = {nyq, 1'b0};
  assign gate_stall = !front_ready;
  assign div_q[0] = '0;
  assign div_rem[0] = '0;

  vfu_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .valid_in    (gate_valid),
    .ready_up    (front_ready),
    .ready_down  (div_ready[0]),
    .valid_q     (div_v[0]),
    .sample      (sample),
    .in_boundary (in_boundary),
    .last_gate   (last_gate),
    .center      (center),
    .nyq         (nyq),
    .bad         (bad),
    .s_q         (div_s[0]),
    .dividend_q  (div_dvd[0]),
    .ctl_q       (div_ctl[0])
  );

  for (genvar k = 0; k < DW; k++) begin : g_div
    vfu_div_stage #(.SAMPLE_BITS(SAMPLE_BITS), .BIT(DW - 1 - k)) u_stage (
      .clk         (clk),
      .rst         (rst),
      .valid_in    (div_v[k]),
      .ready_up    (div_ready[k]),
      .ready_down  (div_ready[k+1]),
      .valid_q     (div_v[k+1]),
      .two_n       (two_n),
      .s_in        (div_s[k]),
      .dividend_in (div_dvd[k]),
      .q_in        (div_q[k]),
      .rem_in      (div_rem[k]),
      .ctl_in      (div_ctl[k]),
      .s_q         (div_s[k+1]),
      .dividend_q  (div_dvd[k+1]),
      .q_q         (div_q[k+1]),
      .rem_q       (div_rem[k+1]),
      .ctl_q       (div_ctl[k+1])
    );
  end

  vfu_fold #(.SAMPLE_BITS(SAMPLE_BITS)) u_fold (
    .clk         (clk),
    .rst         (rst),
    .valid_in    (div_v[DW]),
    .ready_up    (div_ready[DW]),
    .ready_down  (out_ready),
    .valid_q     (fold_v),
    .s_in        (div_s[DW]),
    .dividend_in (div_dvd[DW]),
    .q_in        (div_q[DW]),
    .rem_in      (div_rem[DW]),
    .ctl_in      (div_ctl[DW]),
    .s_q         (fold_s),
    .prod_q      (fold_prod),
    .fold_q      (fold_n),
    .ctl_q       (fold_ctl)
  );

  vfu_out #(.SAMPLE_BITS(SAMPLE_BITS)) u_out (
    .clk        (clk),
    .rst        (rst),
    .valid_in   (fold_v),
    .ready_up   (out_ready),
    .ready_down (!result_stall),
    .valid_q    (result_valid),
    .s_in       (fold_s),
    .prod_in    (fold_prod),
    .fold_in    (fold_n),
    .ctl_in     (fold_ctl),
    .sample_out (sample_out),
    .fold_count (fold_count),
    .saturated  (saturated),
    .last_out   (last_out)
  );

endmodule

/* sv/vfu_front.sv */
`timescale 1ns / 1ps

module vfu_front #(
  parameter int SAMPLE_BITS = vfu_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          valid_in,
  output logic                                          ready_up,
  input  logic                                          ready_down,
  output logic                                          valid_q,
  input  logic signed [SAMPLE_BITS-1:0]                 sample,
  input  logic                                          in_boundary,
  input  logic                                          last_gate,
  input  logic signed [vfu_pkg::CFG_BITS-1:0]           center,
  input  logic [vfu_pkg::NYQ_BITS-1:0]                  nyq,
  input  logic signed [vfu_pkg::CFG_BITS-1:0]           bad,
  output logic signed [SAMPLE_BITS-1:0]                 s_q,
  output logic [vfu_pkg::div_width(SAMPLE_BITS)-1:0]    dividend_q,
  output vfu_pkg::vfu_ctl_t                             ctl_q
);
  import vfu_pkg::*;

  localparam int DW = div_width(SAMPLE_BITS);

  logic signed [DW-1:0] s_ext;
  logic signed [DW-1:0] c_ext;
  logic signed [DW-1:0] b_ext;
  logic signed [DW-1:0] d;
  logic [DW:0]          n_ext;
  logic [DW:0]          sum_p;
  logic [DW:0]          sum_m;
  logic [DW-1:0]        dividend_next;
  vfu_ctl_t             ctl_next;

  assign ready_up = !valid_q || ready_down;

  always_comb begin
    s_ext = DW'(sample);
    c_ext = DW'(center);
    b_ext = DW'(bad);
    d = c_ext - s_ext;
    n_ext = (DW + 1)'(nyq);
    sum_p = n_ext + (DW + 1)'(d);
    sum_m = n_ext - (DW + 1)'(d);
    dividend_next = d[DW-1] ? sum_m[DW-1:0] : sum_p[DW-1:0];
    ctl_next.active = in_boundary && (s_ext != b_ext) && (nyq != '0);
    ctl_next.neg = d[DW-1];
    ctl_next.last = last_gate;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (ready_up) begin
      valid_q <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      s_q <= sample;
      dividend_q <= dividend_next;
      ctl_q <= ctl_next;
    end
  end

endmodule

/* sv/vfu_div_stage.sv */
`timescale 1ns / 1ps

module vfu_div_stage #(
  parameter int SAMPLE_BITS = vfu_pkg::SAMPLE_BITS_DEF,
  parameter int BIT = 0
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          valid_in,
  output logic                                          ready_up,
  input  logic                                          ready_down,
  output logic                                          valid_q,
  input  logic [vfu_pkg::NYQ_BITS:0]                    two_n,
  input  logic signed [SAMPLE_BITS-1:0]                 s_in,
  input  logic [vfu_pkg::div_width(SAMPLE_BITS)-1:0]    dividend_in,
  input  logic [vfu_pkg::div_width(SAMPLE_BITS)-1:0]    q_in,
  input  logic [vfu_pkg::REM_BITS-1:0]                  rem_in,
  input  vfu_pkg::vfu_ctl_t                             ctl_in,
  output logic signed [SAMPLE_BITS-1:0]                 s_q,
  output logic [vfu_pkg::div_width(SAMPLE_BITS)-1:0]    dividend_q,
  output logic [vfu_pkg::div_width(SAMPLE_BITS)-1:0]    q_q,
  output logic [vfu_pkg::REM_BITS-1:0]                  rem_q,
  output vfu_pkg::vfu_ctl_t                             ctl_q
);
  import vfu_pkg::*;

  localparam int DW = div_width(SAMPLE_BITS);

  logic [REM_BITS-1:0] rem_shift;
  logic [REM_BITS-1:0] divisor;
  logic                ge;
  logic [REM_BITS-1:0] rem_next;
  logic [DW-1:0]       q_next;

  assign ready_up = !valid_q || ready_down;

  always_comb begin
    rem_shift = {rem_in[REM_BITS-2:0], dividend_in[BIT]};
    divisor = REM_BITS'(two_n);
    ge = rem_shift >= divisor;
    rem_next = ge ? (rem_shift - divisor) : rem_shift;
    q_next = {q_in[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (ready_up) begin
      valid_q <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      s_q <= s_in;
      dividend_q <= dividend_in;
      q_q <= q_next;
      rem_q <= rem_next;
      ctl_q <= ctl_in;
    end
  end

endmodule

/* sv/vfu_fold.sv */
`timescale 1ns / 1ps

module vfu_fold #(
  parameter int SAMPLE_BITS = vfu_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          valid_in,
  output logic                                          ready_up,
  input  logic                                          ready_down,
  output logic                                          valid_q,
  input  logic signed [SAMPLE_BITS-1:0]                 s_in,
  input  logic [vfu_pkg::div_width(SAMPLE_BITS)-1:0]    dividend_in,
  input  logic [vfu_pkg::div_width(SAMPLE_BITS)-1:0]    q_in,
  input  logic [vfu_pkg::REM_BITS-1:0]                  rem_in,
  input  vfu_pkg::vfu_ctl_t                             ctl_in,
  output logic signed [SAMPLE_BITS-1:0]                 s_q,
  output logic [vfu_pkg::div_width(SAMPLE_BITS)-1:0]    prod_q,
  output logic signed [15:0]                            fold_q,
  output vfu_pkg::vfu_ctl_t                             ctl_q
);
  import vfu_pkg::*;

  localparam int DW = div_width(SAMPLE_BITS);

  logic                 fold;
  logic [DW-1:0]        prod_next;
  logic signed [15:0]   fold_next;
  vfu_ctl_t             ctl_next;

  assign ready_up = !valid_q || ready_down;

  always_comb begin
    // |d| equal to nyquist gives quotient one with no remainder and is not folded
    fold = ctl_in.active && (q_in != '0) && !((q_in == DW'(1)) && (rem_in == '0));
    prod_next = dividend_in - DW'(rem_in);
    if (!fold) begin
      fold_next = '0;
    end else if (ctl_in.neg) begin
      fold_next = (q_in >= DW'(FOLD_NEG_LIMIT)) ? FOLD_MIN : -q_in[15:0];
    end else begin
      fold_next = (q_in > DW'(FOLD_POS_LIMIT)) ? FOLD_MAX : q_in[15:0];
    end
    ctl_next.active = fold;
    ctl_next.neg = ctl_in.neg;
    ctl_next.last = ctl_in.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (ready_up) begin
      valid_q <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      s_q <= s_in;
      prod_q <= prod_next;
      fold_q <= fold_next;
      ctl_q <= ctl_next;
    end
  end

endmodule

/* sv/vfu_out.sv */
`timescale 1ns / 1ps

module vfu_out #(
  parameter int SAMPLE_BITS = vfu_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          valid_in,
  output logic                                          ready_up,
  input  logic                                          ready_down,
  output logic                                          valid_q,
  input  logic signed [SAMPLE_BITS-1:0]                 s_in,
  input  logic [vfu_pkg::div_width(SAMPLE_BITS)-1:0]    prod_in,
  input  logic signed [15:0]                            fold_in,
  input  vfu_pkg::vfu_ctl_t                             ctl_in,
  output logic signed [SAMPLE_BITS-1:0]                 sample_out,
  output logic signed [15:0]                            fold_count,
  output logic                                          saturated,
  output logic                                          last_out
);
  import vfu_pkg::*;

  localparam int DW = div_width(SAMPLE_BITS);
  localparam int SW = DW + 2;
  localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SMIN = SW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  logic signed [SW-1:0]          s_w;
  logic signed [SW-1:0]          p_w;
  logic signed [SW-1:0]          sum;
  logic signed [SAMPLE_BITS-1:0] res_next;
  logic                          sat_next;

  assign ready_up = !valid_q || ready_down;

  always_comb begin
    s_w = SW'(s_in);
    p_w = SW'({2'b00, prod_in});
    sum = ctl_in.neg ? (s_w - p_w) : (s_w + p_w);
    res_next = s_in;
    sat_next = 1'b0;
    if (ctl_in.active) begin
      if (sum > SMAX) begin
        res_next = SMAX[SAMPLE_BITS-1:0];
        sat_next = 1'b1;
      end else if (sum < SMIN) begin
        res_next = SMIN[SAMPLE_BITS-1:0];
        sat_next = 1'b1;
      end else begin
        res_next = sum[SAMPLE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (ready_up) begin
      valid_q <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      sample_out <= res_next;
      fold_count <= fold_in;
      saturated <= sat_next;
      last_out <= ctl_in.last;
    end
  end

endmodule

/* bench/unfold_checker.sv */
`timescale 1ns / 1ps

module unfold_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [vfu_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [vfu_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                         gate_valid,
  input  logic                         gate_stall,
  input  logic signed [15:0]           sample,
  input  logic                         in_boundary,
  input  logic                         last_gate,
  input  logic                         result_valid,
  input  logic                         result_stall,
  input  logic signed [15:0]           sample_out,
  input  logic signed [15:0]           fold_count,
  input  logic                         saturated,
  input  logic                         last_out,
  output int                           mismatches,
  output int                           pending
);
  import vfu_pkg::*;

  localparam longint SMAX = 32767;
  localparam longint SMIN = -32768;

  typedef struct packed {
    logic signed [15:0] value;
    logic signed [15:0] folds;
    logic               clip;
    logic               last;
  } unfold_t;

  logic signed [15:0] ctr_v = CENTER_RESET;
  logic [13:0]        nyq_v = NYQ_RESET;
  logic signed [15:0] bad_v = BAD_RESET;
  unfold_t            pending_unfolds[$];

  function automatic unfold_t unfold_gate(input logic signed [15:0] s, input logic inb,
                                          input logic lg);
    longint  d;
    longint  ad;
    longint  nq;
    longint  mag;
    longint  n;
    longint  sum;
    unfold_t r;
    n = 0;
    sum = longint'(s);
    r.clip = 1'b0;
    r.last = lg;
    nq = longint'(nyq_v);
    if (inb && s != bad_v && nyq_v != 0) begin
      d = longint'(ctr_v) - longint'(s);
      ad = (d < 0) ? -d : d;
      if (ad > nq) begin
        mag = (ad + nq) / (2 * nq);
        n = (d < 0) ? -mag : mag;
        sum = longint'(s) + n * 2 * nq;
        if (sum > SMAX) begin
          sum = SMAX;
          r.clip = 1'b1;
        end else if (sum < SMIN) begin
          sum = SMIN;
          r.clip = 1'b1;
        end
      end
    end
    if (n > 32767) n = 32767;
    else if (n < -32768) n = -32768;
    r.value = sum[15:0];
    r.folds = n[15:0];
    return r;
  endfunction

  always @(posedge clk) begin
    unfold_t want;
    if (rst) begin
      ctr_v <= CENTER_RESET;
      nyq_v <= NYQ_RESET;
      bad_v <= BAD_RESET;
      pending_unfolds.delete();
      pending <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_CENTER:  ctr_v <= cfg_data;
          REG_NYQUIST: nyq_v <= cfg_data[13:0];
          REG_BAD:     bad_v <= cfg_data;
          default: ;
        endcase
      end
      if (gate_valid && !gate_stall)
        pending_unfolds.push_back(unfold_gate(sample, in_boundary, last_gate));
      if (result_valid && !result_stall) begin
        if (pending_unfolds.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result transaction: out %0d folds %0d sat %0b last %0b",
                     sample_out, fold_count, saturated, last_out);
          mismatches <= mismatches + 1;
        end else begin
          want = pending_unfolds.pop_front();
          if (want.value !== sample_out || want.folds !== fold_count ||
              want.clip !== saturated || want.last !== last_out) begin
            if (mismatches < 10) begin
              $display("mismatch: exp out %0d folds %0d sat %0b last %0b",
                       want.value, want.folds, want.clip, want.last);
              $display("          got out %0d folds %0d sat %0b last %0b",
                       sample_out, fold_count, saturated, last_out);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      pending <= pending_unfolds.size();
    end
  end

endmodule

/* bench/tb_velocity_forced_unfold.sv */
`timescale 1ns / 1ps

module tb_velocity_forced_unfold;
  import vfu_pkg::*;

  localparam logic [IDX_BITS-1:0] REG_NONE = 2'd3;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 55;
  localparam int CALM_PHASE = 2;
  localparam int HOLD_PHASE = 5;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE = 30;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic                gate_valid = 1'b0;
  logic                gate_stall;
  logic signed [15:0]  sample = '0;
  logic                in_boundary = 1'b0;
  logic                last_gate = 1'b0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic signed [15:0]  sample_out;
  logic signed [15:0]  fold_count;
  logic                saturated;
  logic                last_out;
  int                  mismatches;
  int                  pending;

  bit calm = 1'b0;
  int hold_reqs = 0;
  int cur_center = 0;
  int cur_nyq = 1;
  int cur_bad = -32768;

  velocity_forced_unfold #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) uut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .gate_valid(gate_valid), .gate_stall(gate_stall),
    .sample(sample), .in_boundary(in_boundary), .last_gate(last_gate),
    .result_valid(result_valid), .result_stall(result_stall),
    .sample_out(sample_out), .fold_count(fold_count),
    .saturated(saturated), .last_out(last_out)
  );

  unfold_checker chk (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .gate_valid(gate_valid), .gate_stall(gate_stall),
    .sample(sample), .in_boundary(in_boundary), .last_gate(last_gate),
    .result_valid(result_valid), .result_stall(result_stall),
    .sample_out(sample_out), .fold_count(fold_count),
    .saturated(saturated), .last_out(last_out),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_velocity_forced_unfold failed");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    int holds_seen;
    hold_left = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_seen) begin
        holds_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else if (calm) begin
        result_stall <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(0, 99) < 13);
      end
    end
  end

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(input int c, input int nq, input int b);
    write_reg(REG_CENTER, 16'(c));
    write_reg(REG_NYQUIST, {2'($urandom), 14'(nq)});
    write_reg(REG_BAD, 16'(b));
    if ($urandom_range(0, 1)) write_reg(REG_NONE, 16'($urandom));
    cfg_wr_en <= 1'b0;
    cur_center = c;
    cur_nyq = nq;
    cur_bad = b;
  endtask

  task automatic send_gate(input logic [15:0] s, input logic inb, input logic lg);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(0, 99) < 13) gap++;
    if (gap > 0) begin
      gate_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    gate_valid <= 1'b1;
    sample <= s;
    in_boundary <= inb;
    last_gate <= lg;
    @(posedge clk);
    while (gate_stall) @(posedge clk);
  endtask

  task automatic wait_empty();
    gate_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // aim at the fold boundaries and half-interval points around the center
  function automatic logic [15:0] pick_sample();
    int v;
    int sg;
    int m;
    sg = $urandom_range(0, 1) ? 1 : -1;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 1) ? 32767 : -32768;
      1: v = cur_bad;
      2: v = cur_center - sg * (cur_nyq + int'($urandom_range(0, 2)) - 1);
      3, 4: begin
        m = 2 * int'($urandom_range(0, 3)) + 1;
        v = cur_center - sg * m * cur_nyq + int'($urandom_range(0, 2)) - 1;
      end
      default: v = int'($urandom_range(0, 65535));
    endcase
    return 16'(v);
  endfunction

  initial begin
    int p;
    int i;
    int c;
    int nq;
    int b;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: center 0, nyquist 1, bad -32768
    send_gate(16'(32767), 1'b1, 1'b0);
    send_gate(16'(-32768), 1'b1, 1'b0);
    send_gate(16'(-32767), 1'b1, 1'b0);
    send_gate(16'(1), 1'b1, 1'b0);
    send_gate(16'(2), 1'b1, 1'b0);
    send_gate(16'(3), 1'b1, 1'b1);
    send_gate(16'(32767), 1'b0, 1'b1);
    wait_empty();

    // fold count beyond 16 bits and clipped sum
    load_settings(32767, 1, 0);
    send_gate(16'(-32768), 1'b1, 1'b0);
    send_gate(16'(0), 1'b1, 1'b0);
    send_gate(16'(-1), 1'b1, 1'b1);
    send_gate(16'(-32767), 1'b1, 1'b0);
    wait_empty();

    load_settings(-32768, 16383, 32767);
    send_gate(16'(32767), 1'b1, 1'b0);
    send_gate(16'(32766), 1'b1, 1'b0);
    send_gate(16'(16381), 1'b1, 1'b1);
    send_gate(16'(16382), 1'b1, 1'b0);
    wait_empty();

    // zero nyquist: nothing unfolds
    load_settings(100, 0, 5);
    send_gate(16'(-30000), 1'b1, 1'b0);
    send_gate(16'(30000), 1'b1, 1'b1);
    send_gate(16'(-32768), 1'b1, 1'b0);
    wait_empty();

    // exact boundary and half-interval rounding both ways
    load_settings(0, 100, -32768);
    send_gate(16'(-100), 1'b1, 1'b0);
    send_gate(16'(-101), 1'b1, 1'b0);
    send_gate(16'(-300), 1'b1, 1'b0);
    send_gate(16'(300), 1'b1, 1'b0);
    send_gate(16'(-299), 1'b1, 1'b1);
    send_gate(16'(100), 1'b1, 1'b0);
    wait_empty();

    for (p = 0; p < RAND_PHASES; p++) begin
      calm <= (p == CALM_PHASE);
      case ($urandom_range(0, 4))
        0: c = 32767;
        1: c = -32768;
        default: c = int'($urandom_range(0, 65535)) - 32768;
      endcase
      case ($urandom_range(0, 9))
        0: nq = 1;
        1: nq = 16383;
        2, 3, 4: nq = $urandom_range(1, 64);
        9: nq = 0;
        default: nq = $urandom_range(1, 16383);
      endcase
      case ($urandom_range(0, 3))
        0: b = -32768;
        1: b = 32767;
        default: b = int'($urandom_range(0, 65535)) - 32768;
      endcase
      load_settings(c, nq, b);
      if (p == HOLD_PHASE) hold_reqs <= hold_reqs + 1;
      for (i = 0; i < PHASE_ITEMS; i++)
        send_gate(pick_sample(), ($urandom_range(0, 99) < 85), ($urandom_range(0, 7) == 0));
      wait_empty();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("tb_velocity_forced_unfold passed");
    end else begin
      $display("tb_velocity_forced_unfold failed");
    end
    $finish;
  end

endmodule
